### rtl/gbr_pkg.sv
package gbr_pkg;

   localparam int unsigned CH_W        = 8;
   localparam int unsigned NUM_CH      = 4;
   localparam int unsigned PIX_W       = CH_W * NUM_CH;
   localparam int unsigned KSIZE       = 5;
   localparam int unsigned NUM_CLASS   = 6;
   localparam int unsigned LINE_ROWS   = 8;
   localparam int unsigned SLOT_W      = 3;
   localparam int unsigned DIM_LO      = 5;
   localparam int unsigned HEIGHT_CAP  = 2048;
   localparam int unsigned ROW_W       = 11;
   localparam int unsigned DIM_REG_W   = 12;
   localparam int unsigned WEIGHT_W    = 16;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSUM_W      = 11;
   localparam int unsigned PROD_W      = CSUM_W + WEIGHT_W;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;

   localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 12'd480;

   typedef enum logic [0:0] {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH      = 3'd0,
      REG_IMAGE_HEIGHT     = 3'd1,
      REG_WEIGHT_CENTER    = 3'd2,
      REG_WEIGHT_AXIS_NEAR = 3'd3,
      REG_WEIGHT_AXIS_FAR  = 3'd4,
      REG_WEIGHT_DIAG_NEAR = 3'd5,
      REG_WEIGHT_KNIGHT    = 3'd6,
      REG_WEIGHT_DIAG_FAR  = 3'd7
   } reg_index_type;

   localparam int unsigned CLS_CENTER    = 0;
   localparam int unsigned CLS_AXIS_NEAR = 1;
   localparam int unsigned CLS_AXIS_FAR  = 2;
   localparam int unsigned CLS_DIAG_NEAR = 3;
   localparam int unsigned CLS_KNIGHT    = 4;
   localparam int unsigned CLS_DIAG_FAR  = 5;

   typedef logic [NUM_CLASS-1:0][WEIGHT_W-1:0] weight_set_type;

   localparam weight_set_type WEIGHT_RESET = {
      16'd195, 16'd873, 16'd3907, 16'd1437, 16'd6443, 16'd10625
   };

   typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [1:0]        top_gap;
      logic [1:0]        bot_gap;
      logic              first;
      logic              last;
   } tap_ctl_type;

   function automatic int unsigned tap_class(input int row, input int col);
      int dy;
      int dx;
      int unsigned cls;
      dy = (row < 2) ? 2 - row : row - 2;
      dx = (col < 2) ? 2 - col : col - 2;
      if (dy == 0 && dx == 0) begin
         cls = CLS_CENTER;
      end else if (dy + dx == 1) begin
         cls = CLS_AXIS_NEAR;
      end else if ((dy == 0 && dx == 2) || (dy == 2 && dx == 0)) begin
         cls = CLS_AXIS_FAR;
      end else if (dy == 1 && dx == 1) begin
         cls = CLS_DIAG_NEAR;
      end else if (dy + dx == 3) begin
         cls = CLS_KNIGHT;
      end else begin
         cls = CLS_DIAG_FAR;
      end
      return cls;
   endfunction

endpackage

### rtl/gbr_ifs.sv
interface gbr_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [gbr_pkg::CH_W-1:0]  in_red;
   logic [gbr_pkg::CH_W-1:0]  in_green;
   logic [gbr_pkg::CH_W-1:0]  in_blue;
   logic [gbr_pkg::CH_W-1:0]  in_alpha;

   modport source (output valid, cmd, in_red, in_green, in_blue, in_alpha, input ready);
   modport sink (input valid, cmd, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface gbr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [gbr_pkg::CH_W-1:0]  out_red;
   logic [gbr_pkg::CH_W-1:0]  out_green;
   logic [gbr_pkg::CH_W-1:0]  out_blue;
   logic [gbr_pkg::CH_W-1:0]  out_alpha;
   logic                      frame_last;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_last,
                   input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_last,
                 output ready);
endinterface

interface gbr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gbr_pkg::CSR_IDX_W-1:0]    index;
   logic [gbr_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/gbr_queue.sv
module gbr_queue #(
   parameter int unsigned DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   logic [DATA_W-1:0]          entry_ff [gbr_pkg::QUEUE_DEPTH];
   logic [gbr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gbr_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gbr_pkg::QPTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (gbr_pkg::QPTR_W + 1)'(gbr_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + gbr_pkg::QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + gbr_pkg::QPTR_W'(pop);
      count_in  = count_ff + (gbr_pkg::QPTR_W + 1)'(push) - (gbr_pkg::QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/gbr_front.sv
module gbr_front #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   gbr_req_if.sink                      req_bus,
   gbr_csr_if.sink                      csr_bus,
   output gbr_pkg::weight_set_type      weights,
   output logic                         wr_en,
   output logic [gbr_pkg::SLOT_W-1:0]   wr_slot,
   output logic [$clog2(MAX_WIDTH)-1:0] wr_col,
   output gbr_pkg::pixel_type           wr_data,
   output logic                         push,
   output gbr_pkg::tap_ctl_type         push_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0] push_col,
   input  logic                         q_full
);

   localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
   localparam int unsigned DIM_W  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned FEED_W = DIM_W + 1;
   localparam int unsigned PEND_W = $clog2(2 * MAX_WIDTH + 8);
   localparam int unsigned HDIM_W = gbr_pkg::DIM_REG_W;

   logic [gbr_pkg::DIM_REG_W-1:0] width_ff, width_in;
   logic [gbr_pkg::DIM_REG_W-1:0] height_ff, height_in;
   gbr_pkg::weight_set_type       weight_ff, weight_in;

   logic [COL_W-1:0]              in_col_ff, in_col_in;
   logic [gbr_pkg::ROW_W-1:0]     in_row_ff, in_row_in;
   logic [COL_W-1:0]              out_col_ff, out_col_in;
   logic [gbr_pkg::ROW_W-1:0]     out_row_ff, out_row_in;
   logic [PEND_W-1:0]             pend_ff, pend_in;
   logic [gbr_pkg::SLOT_W-1:0]    in_slot_ff, in_slot_in;
   logic [gbr_pkg::SLOT_W-1:0]    out_slot_ff, out_slot_in;

   logic                          cfg_write;
   logic                          restart;
   logic                          accept;
   logic                          pixel;
   logic [DIM_W-1:0]              w_eff;
   logic [DIM_W-1:0]              w_last;
   logic [HDIM_W-1:0]             h_eff;
   logic [HDIM_W-1:0]             h_last;
   logic                          in_col_wrap;
   logic                          in_row_wrap;
   logic                          out_col_wrap;
   logic                          out_row_wrap;
   logic [HDIM_W-1:0]             rows_left;
   logic [DIM_W-1:0]              cols_left;
   logic [PEND_W-1:0]             need_gap;
   logic [PEND_W-1:0]             pend_inc;
   logic                          release_out;
   logic [FEED_W-1:0]             feed_pos;

   assign cfg_write     = csr_bus.valid && csr_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign pixel         = accept && (req_bus.cmd == gbr_pkg::CMD_PIXEL);
   assign weights       = weight_ff;

   always_comb begin
      if (width_ff < gbr_pkg::DIM_REG_W'(gbr_pkg::DIM_LO)) begin
         w_eff = DIM_W'(gbr_pkg::DIM_LO);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = DIM_W'(width_ff);
      end
      if (height_ff < gbr_pkg::DIM_REG_W'(gbr_pkg::DIM_LO)) begin
         h_eff = HDIM_W'(gbr_pkg::DIM_LO);
      end else if (32'(height_ff) > gbr_pkg::HEIGHT_CAP) begin
         h_eff = HDIM_W'(gbr_pkg::HEIGHT_CAP);
      end else begin
         h_eff = height_ff;
      end
      w_last = w_eff - DIM_W'(1);
      h_last = h_eff - HDIM_W'(1);
   end

   always_comb begin
      in_col_wrap  = (DIM_W'(in_col_ff) == w_last);
      in_row_wrap  = (HDIM_W'(in_row_ff) == h_last);
      out_col_wrap = (DIM_W'(out_col_ff) == w_last);
      out_row_wrap = (HDIM_W'(out_row_ff) == h_last);
      rows_left    = h_last - HDIM_W'(out_row_ff);
      cols_left    = w_last - DIM_W'(out_col_ff);
      if (rows_left >= HDIM_W'(2)) begin
         need_gap = PEND_W'(w_eff) << 1;
      end else if (rows_left == HDIM_W'(1)) begin
         need_gap = PEND_W'(w_eff);
      end else begin
         need_gap = '0;
      end
      if (cols_left >= DIM_W'(2)) begin
         need_gap = need_gap + PEND_W'(2);
      end else begin
         need_gap = need_gap + PEND_W'(cols_left);
      end
      pend_inc    = pend_ff + PEND_W'(pixel);
      release_out = accept && (pend_inc > need_gap);
      feed_pos    = FEED_W'(out_col_ff) + FEED_W'(2);
   end

   always_comb begin
      push             = release_out;
      push_ctl.slot    = out_slot_ff;
      push_ctl.first   = (out_col_ff == '0);
      push_ctl.last    = out_col_wrap && out_row_wrap;
      push_ctl.top_gap = (out_row_ff >= gbr_pkg::ROW_W'(2)) ? 2'd2 : out_row_ff[1:0];
      push_ctl.bot_gap = (rows_left >= HDIM_W'(2)) ? 2'd2 : rows_left[1:0];
      if (feed_pos < FEED_W'(w_eff)) begin
         push_col = COL_W'(feed_pos);
      end else begin
         push_col = COL_W'(w_last);
      end
   end

   assign wr_en   = pixel;
   assign wr_slot = in_slot_ff;
   assign wr_col  = in_col_ff;
   assign wr_data = {req_bus.in_alpha, req_bus.in_blue, req_bus.in_green, req_bus.in_red};

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      weight_in = weight_ff;
      restart   = 1'b0;
      if (cfg_write) begin
         unique case (gbr_pkg::reg_index_type'(csr_bus.index))
            gbr_pkg::REG_IMAGE_WIDTH: begin
               width_in = csr_bus.data[gbr_pkg::DIM_REG_W-1:0];
               restart  = 1'b1;
            end
            gbr_pkg::REG_IMAGE_HEIGHT: begin
               height_in = csr_bus.data[gbr_pkg::DIM_REG_W-1:0];
               restart   = 1'b1;
            end
            gbr_pkg::REG_WEIGHT_CENTER: weight_in[gbr_pkg::CLS_CENTER] = csr_bus.data;
            gbr_pkg::REG_WEIGHT_AXIS_NEAR: weight_in[gbr_pkg::CLS_AXIS_NEAR] = csr_bus.data;
            gbr_pkg::REG_WEIGHT_AXIS_FAR: weight_in[gbr_pkg::CLS_AXIS_FAR] = csr_bus.data;
            gbr_pkg::REG_WEIGHT_DIAG_NEAR: weight_in[gbr_pkg::CLS_DIAG_NEAR] = csr_bus.data;
            gbr_pkg::REG_WEIGHT_KNIGHT: weight_in[gbr_pkg::CLS_KNIGHT] = csr_bus.data;
            gbr_pkg::REG_WEIGHT_DIAG_FAR: weight_in[gbr_pkg::CLS_DIAG_FAR] = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      pend_in     = pend_inc - PEND_W'(release_out);
      if (pixel) begin
         if (in_col_wrap) begin
            in_col_in  = '0;
            in_slot_in = in_slot_ff + gbr_pkg::SLOT_W'(1);
            in_row_in  = in_row_wrap ? '0 : in_row_ff + gbr_pkg::ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
      if (release_out) begin
         if (out_col_wrap) begin
            out_col_in  = '0;
            out_slot_in = out_slot_ff + gbr_pkg::SLOT_W'(1);
            out_row_in  = out_row_wrap ? '0 : out_row_ff + gbr_pkg::ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
      if (restart) begin
         in_col_in   = '0;
         in_row_in   = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         pend_in     = '0;
         in_slot_in  = in_slot_ff;
         out_slot_in = in_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= gbr_pkg::WIDTH_RESET;
         height_ff   <= gbr_pkg::HEIGHT_RESET;
         weight_ff   <= gbr_pkg::WEIGHT_RESET;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         pend_ff     <= '0;
         in_slot_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         weight_ff   <= weight_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         pend_ff     <= pend_in;
         in_slot_ff  <= in_slot_in;
         out_slot_ff <= out_slot_in;
      end
   end

endmodule

### rtl/gbr_back.sv
module gbr_back #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [gbr_pkg::SLOT_W-1:0]   wr_slot,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
   input  gbr_pkg::pixel_type           wr_data,
   input  logic                         q_empty,
   input  gbr_pkg::tap_ctl_type         q_ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
   output logic                         q_pop,
   input  gbr_pkg::weight_set_type      weights,
   gbr_rsp_if.source                    rsp_bus
);

   localparam int unsigned K      = gbr_pkg::KSIZE;
   localparam int unsigned NCH    = gbr_pkg::NUM_CH;
   localparam int unsigned NCL    = gbr_pkg::NUM_CLASS;
   localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
   localparam int unsigned WBITS  = gbr_pkg::WEIGHT_W;
   localparam int unsigned SUM_W  = gbr_pkg::PROD_W + 3;
   localparam int unsigned ACC_W  = ((SUM_W > WBITS) ? SUM_W : WBITS) + 1;
   localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (WBITS - 1);
   localparam logic [ACC_W-1:0] SAT   = ACC_W'(255);

   typedef logic [K-1:0][K-1:0][gbr_pkg::PIX_W-1:0]     window_type;
   typedef logic [NCH-1:0][NCL-1:0][gbr_pkg::CSUM_W-1:0] csum_type;
   typedef logic [NCH-1:0][NCL-1:0][gbr_pkg::PROD_W-1:0] prod_type;

   logic                                      advance;
   gbr_pkg::pixel_type                        rd_ff [gbr_pkg::LINE_ROWS];
   logic [gbr_pkg::LINE_ROWS-1:0][1:0][gbr_pkg::PIX_W-1:0] head_ff;

   logic                       v1_ff, v2_ff, v3_ff, v4_ff;
   gbr_pkg::tap_ctl_type       ctl1_ff;
   logic                       last2_ff, last3_ff, last4_ff;
   window_type                 win_ff, win_in;
   csum_type                   csum_ff, csum_in;
   prod_type                   prod_ff, prod_in;
   logic [K-1:0][gbr_pkg::SLOT_W-1:0] row_slot;

   logic                       rsp_valid_ff;
   gbr_pkg::pixel_type         rsp_pix_ff, rsp_pix_in;
   logic                       rsp_last_ff;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign q_pop   = advance && !q_empty;

   for (genvar b = 0; b < gbr_pkg::LINE_ROWS; b++) begin : gen_bank
      gbr_pkg::pixel_type line_mem [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (wr_en && (wr_slot == gbr_pkg::SLOT_W'(b))) begin
            line_mem[wr_col] <= wr_data;
         end
         if (advance) begin
            rd_ff[b] <= line_mem[q_col];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_col < COL_W'(2))) begin
         head_ff[wr_slot][wr_col[0]] <= wr_data;
      end
   end

   always_comb begin
      row_slot[0] = ctl1_ff.slot - gbr_pkg::SLOT_W'(ctl1_ff.top_gap);
      row_slot[1] = ctl1_ff.slot - gbr_pkg::SLOT_W'(ctl1_ff.top_gap != 2'd0);
      row_slot[2] = ctl1_ff.slot;
      row_slot[3] = ctl1_ff.slot + gbr_pkg::SLOT_W'(ctl1_ff.bot_gap != 2'd0);
      row_slot[4] = ctl1_ff.slot + gbr_pkg::SLOT_W'(ctl1_ff.bot_gap);
   end

   always_comb begin
      win_in = win_ff;
      if (v1_ff) begin
         for (int r = 0; r < K; r++) begin
            if (ctl1_ff.first) begin
               win_in[r][0] = head_ff[row_slot[r]][0];
               win_in[r][1] = head_ff[row_slot[r]][0];
               win_in[r][2] = head_ff[row_slot[r]][0];
               win_in[r][3] = head_ff[row_slot[r]][1];
            end else begin
               for (int c = 0; c < K - 1; c++) begin
                  win_in[r][c] = win_ff[r][c + 1];
               end
            end
            win_in[r][K - 1] = rd_ff[row_slot[r]];
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         for (int k = 0; k < NCL; k++) begin
            csum_in[ch][k] = '0;
            for (int r = 0; r < K; r++) begin
               for (int c = 0; c < K; c++) begin
                  if (gbr_pkg::tap_class(r, c) == k) begin
                     csum_in[ch][k] = csum_in[ch][k]
                                    + gbr_pkg::CSUM_W'(win_ff[r][c][ch * gbr_pkg::CH_W +:
                                                                   gbr_pkg::CH_W]);
                  end
               end
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         for (int k = 0; k < NCL; k++) begin
            prod_in[ch][k] = gbr_pkg::PROD_W'(csum_ff[ch][k]) * gbr_pkg::PROD_W'(weights[k]);
         end
      end
   end

   always_comb begin
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] scaled;
      for (int ch = 0; ch < NCH; ch++) begin
         acc = ROUND;
         for (int k = 0; k < NCL; k++) begin
            acc = acc + ACC_W'(prod_ff[ch][k]);
         end
         scaled = acc >> WBITS;
         rsp_pix_in[ch] = (scaled > SAT) ? 8'hFF : scaled[gbr_pkg::CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= !q_empty;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl1_ff     <= q_ctl;
         win_ff      <= win_in;
         last2_ff    <= ctl1_ff.last;
         csum_ff     <= csum_in;
         last3_ff    <= last2_ff;
         prod_ff     <= prod_in;
         last4_ff    <= last3_ff;
         rsp_pix_ff  <= rsp_pix_in;
         rsp_last_ff <= last4_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_red    = rsp_pix_ff[0];
   assign rsp_bus.out_green  = rsp_pix_ff[1];
   assign rsp_bus.out_blue   = rsp_pix_ff[2];
   assign rsp_bus.out_alpha  = rsp_pix_ff[3];
   assign rsp_bus.frame_last = rsp_last_ff;

endmodule

### rtl/gaussian_blur_5x5_rgba_core.sv
// Streaming 5x5 Gaussian blur for RGBA8 pixels in raster order.
// The req channel carries one transfer per pixel; a flush command carries no
// pixel and lets the outputs still pending at the end of a frame drain.
// The rsp channel carries one blurred pixel per center position, in raster
// order, with frame_last set on the final pixel of a frame.
// The csr channel writes image width, image height and six Q0.16 weights.
// It is always ready; write it only while the block is idle. Writing the
// width or height restarts the frame and drops the outputs still pending.
// Throughput is one pixel per cycle on both channels while rsp is not
// stalled. The first output of a frame follows the pixel two rows and two
// columns below it; near the bottom edge the last outputs wait for flush
// commands or the next frame. An output leaves the rsp register after the
// req transfer that releases it passes the queue, the line store read, the
// window update, the class sums, the weight products and the sum.
// When rsp is stalled the back pipeline holds and the four-entry queue
// fills, after which req is no longer ready.
// Reset clears the counters and loads the default 640x480 frame and weights;
// the line stores are not cleared.
module gaussian_blur_5x5_rgba_core #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic       clock,
   input  logic       reset,
   gbr_req_if.sink    req_bus,
   gbr_rsp_if.source  rsp_bus,
   gbr_csr_if.sink    csr_bus
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned QD_W  = $bits(gbr_pkg::tap_ctl_type) + COL_W;

   gbr_pkg::weight_set_type     weights;
   logic                        wr_en;
   logic [gbr_pkg::SLOT_W-1:0]  wr_slot;
   logic [COL_W-1:0]            wr_col;
   gbr_pkg::pixel_type          wr_data;
   logic                        push;
   gbr_pkg::tap_ctl_type        push_ctl;
   logic [COL_W-1:0]            push_col;
   logic                        q_full;
   logic                        q_empty;
   logic                        q_pop;
   logic [QD_W-1:0]             q_data;
   gbr_pkg::tap_ctl_type        q_ctl;
   logic [COL_W-1:0]            q_col;

   gbr_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .weights  (weights),
      .wr_en    (wr_en),
      .wr_slot  (wr_slot),
      .wr_col   (wr_col),
      .wr_data  (wr_data),
      .push     (push),
      .push_ctl (push_ctl),
      .push_col (push_col),
      .q_full   (q_full)
   );

   gbr_queue #(
      .DATA_W(QD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_col}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign q_ctl = gbr_pkg::tap_ctl_type'(q_data[QD_W-1:COL_W]);
   assign q_col = q_data[COL_W-1:0];

   gbr_back #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_slot (wr_slot),
      .wr_col  (wr_col),
      .wr_data (wr_data),
      .q_empty (q_empty),
      .q_ctl   (q_ctl),
      .q_col   (q_col),
      .q_pop   (q_pop),
      .weights (weights),
      .rsp_bus (rsp_bus)
   );

endmodule
